/* rtl/core/cbc_pkg.sv */
// cbc_pkg: shared widths, constants and types of the color blob centroid unit
// no dependencies; used by the interfaces and every module of the block

package cbc_pkg;

  localparam int ColorW = 8;
  localparam int CoordW = 10;
  localparam int SumW   = 30;
  localparam int CntW   = 21;
  localparam int QuotW  = CoordW;
  localparam int StepW  = $clog2(QuotW);

  // frame size limits; coordinates at or beyond them are clamped to the edge
  localparam int MaxCols = 1024;
  localparam int MaxRows = 1024;

  typedef struct packed {
    logic [ColorW-1:0] red;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] blue;
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
    logic              last_pixel;
  } pix_t;

  typedef struct packed {
    logic              found;
    logic [CoordW-1:0] centroid_col;
    logic [CoordW-1:0] centroid_row;
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic             acc_en;     // pixel transfer, update the sums
    logic             frame_end;  // last pixel transfer, hand sums to the divider
    logic             div_en;     // one quotient bit
    logic [StepW-1:0] step;       // quotient bit position
    logic             load_out;   // move the quotient into the output register
  } cmd_t;

  // handshake status seen by the controller
  typedef struct packed {
    logic pix_valid;
    logic pix_last;
    logic res_ready;
  } stat_t;

endpackage

/* rtl/core/cbc_if.sv */
// cbc_pix_if and cbc_res_if: valid/ready channels of the centroid unit
// depends on cbc_pkg

interface cbc_pix_if;
  import cbc_pkg::*;
  logic valid;
  logic ready;
  pix_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cbc_res_if;
  import cbc_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/cbc_ctrl.sv */
// cbc_ctrl: state machine of the centroid unit, sequences accumulate, divide, output
// depends on cbc_pkg

module cbc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cbc_pkg::stat_t stat_i,
  output cbc_pkg::cmd_t  cmd_o,
  output logic           pix_ready_o,
  output logic           res_valid_o
);
  import cbc_pkg::*;

  localparam logic [1:0] StAcc  = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StHold = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic             out_valid_q, out_valid_d;
  logic             pix_fire;
  logic             out_free;

  assign pix_ready_o = (state_q == StAcc);
  assign pix_fire    = pix_ready_o & stat_i.pix_valid;
  assign out_free    = ~out_valid_q | stat_i.res_ready;
  assign res_valid_o = out_valid_q;

  always_comb begin
    state_d        = state_q;
    step_d         = step_q;
    cmd_o          = '0;
    cmd_o.step     = step_q;
    cmd_o.acc_en   = pix_fire;
    unique case (state_q)
      StAcc: begin
        if (pix_fire && stat_i.pix_last) begin
          cmd_o.frame_end = 1'b1;
          step_d          = StepW'(QuotW - 1);
          state_d         = StDiv;
        end
      end
      StDiv: begin
        cmd_o.div_en = 1'b1;
        if (step_q == '0) begin
          state_d = StHold;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      StHold: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = StAcc;
        end
      end
      default: begin
        state_d = StAcc;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (stat_i.res_ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StAcc;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* rtl/core/cbc_datapath.sv */
// cbc_datapath: color test, saturating sums, two-lane restoring divider, result register
// depends on cbc_pkg

module cbc_datapath (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cbc_pkg::cmd_t cmd_i,
  input  cbc_pkg::pix_t pix_i,
  output cbc_pkg::res_t res_o
);
  import cbc_pkg::*;

  logic [SumW-1:0]   col_sum_q, col_sum_d, row_sum_q, row_sum_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [SumW-1:0]   rem_col_q, rem_col_d, rem_row_q, rem_row_d;
  logic [CntW-1:0]   dvs_q, dvs_d;
  logic [QuotW-1:0]  quo_col_q, quo_col_d, quo_row_q, quo_row_d;
  logic              found_q, found_d;
  res_t              res_q;

  logic [CoordW-1:0] col_c, row_c;
  logic [ColorW+2:0] red5, green5, blue_x;
  logic              hit;
  logic [SumW:0]     col_add, row_add;
  logic [SumW-1:0]   col_acc, row_acc;
  logic [CntW-1:0]   cnt_acc;
  logic [SumW-1:0]   trial;
  logic              col_ge, row_ge;

  // clamp coordinates to the frame
  always_comb begin
    col_c = pix_i.col;
    row_c = pix_i.row;
    if (int'(pix_i.col) >= MaxCols) col_c = CoordW'(MaxCols - 1);
    if (int'(pix_i.row) >= MaxRows) row_c = CoordW'(MaxRows - 1);
  end

  // a hit: blue beats five times red and five times green, and the hit count is not full
  assign red5   = ({3'b0, pix_i.red} << 2) + {3'b0, pix_i.red};
  assign green5 = ({3'b0, pix_i.green} << 2) + {3'b0, pix_i.green};
  assign blue_x = {3'b0, pix_i.blue};
  assign hit    = (blue_x > red5) && (blue_x > green5) && (cnt_q != '1);

  assign col_add = {1'b0, col_sum_q} + {(SumW + 1 - CoordW)'(0), col_c};
  assign row_add = {1'b0, row_sum_q} + {(SumW + 1 - CoordW)'(0), row_c};

  always_comb begin
    col_acc = col_sum_q;
    row_acc = row_sum_q;
    cnt_acc = cnt_q;
    if (hit) begin
      col_acc = col_add[SumW] ? '1 : col_add[SumW-1:0];
      row_acc = row_add[SumW] ? '1 : row_add[SumW-1:0];
      cnt_acc = cnt_q + 1'b1;
    end
  end

  always_comb begin
    col_sum_d = col_sum_q;
    row_sum_d = row_sum_q;
    cnt_d     = cnt_q;
    if (cmd_i.frame_end) begin
      col_sum_d = '0;
      row_sum_d = '0;
      cnt_d     = '0;
    end else if (cmd_i.acc_en) begin
      col_sum_d = col_acc;
      row_sum_d = row_acc;
      cnt_d     = cnt_acc;
    end
  end

  // restoring division, one quotient bit per cycle in each lane
  assign trial  = {(SumW - CntW)'(0), dvs_q} << cmd_i.step;
  assign col_ge = rem_col_q >= trial;
  assign row_ge = rem_row_q >= trial;

  always_comb begin
    rem_col_d = rem_col_q;
    rem_row_d = rem_row_q;
    dvs_d     = dvs_q;
    quo_col_d = quo_col_q;
    quo_row_d = quo_row_q;
    found_d   = found_q;
    if (cmd_i.frame_end) begin
      rem_col_d = col_acc;
      rem_row_d = row_acc;
      dvs_d     = cnt_acc;
      quo_col_d = '0;
      quo_row_d = '0;
      found_d   = (cnt_acc != '0);
    end else if (cmd_i.div_en) begin
      if (col_ge) rem_col_d = rem_col_q - trial;
      if (row_ge) rem_row_d = rem_row_q - trial;
      quo_col_d = {quo_col_q[QuotW-2:0], col_ge};
      quo_row_d = {quo_row_q[QuotW-2:0], row_ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_sum_q <= '0;
      row_sum_q <= '0;
      cnt_q     <= '0;
    end else begin
      col_sum_q <= col_sum_d;
      row_sum_q <= row_sum_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_col_q <= rem_col_d;
    rem_row_q <= rem_row_d;
    dvs_q     <= dvs_d;
    quo_col_q <= quo_col_d;
    quo_row_q <= quo_row_d;
    found_q   <= found_d;
    if (cmd_i.load_out) begin
      res_q.found        <= found_q;
      res_q.centroid_col <= found_q ? quo_col_q : '0;
      res_q.centroid_row <= found_q ? quo_row_q : '0;
    end
  end

  assign res_o = res_q;

endmodule

/* rtl/core/color_blob_centroid_unit.sv */
// color_blob_centroid_unit: top level of the color blob centroid block
// depends on cbc_pkg, cbc_if, cbc_ctrl and cbc_datapath
//
// usage
//   pix_i takes one pixel per transfer: red, green, blue, col, row and
//   last_pixel. a pixel is a hit when blue > 5*red and blue > 5*green; hits
//   add col, row and one to saturating running sums
//   res_o gives one transfer per frame, after the pixel marked last_pixel:
//   found plus the truncated mean column and row of the hits (zero if none)
//   throughput: one pixel per cycle inside a frame. after the last pixel the
//   input stalls while the 10-bit restoring divider works out both means,
//   one quotient bit per cycle, then pixels flow again
//   the result is loaded once the division ends and the output is free
//   a result waits in the output register while the next frame streams in;
//   if the receiver still holds off when the next frame's division ends, the
//   input stays stalled until that result is taken
//   reset clears the sums, the controller and the output valid flag

module color_blob_centroid_unit (
  input logic       clk_i,
  input logic       rst_ni,
  cbc_pix_if.sink   pix_i,
  cbc_res_if.source res_o
);
  import cbc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // handshake status for the controller
  assign stat.pix_valid = pix_i.valid;
  assign stat.pix_last  = pix_i.data.last_pixel;
  assign stat.res_ready = res_o.ready;

  // sequencing: accumulate, divide, hand over the result
  cbc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .pix_ready_o (pix_i.ready),
    .res_valid_o (res_o.valid)
  );

  // sums, divider and the output register
  cbc_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .pix_i  (pix_i.data),
    .res_o  (res_o.data)
  );

endmodule
